>>> design/mwpo_pkg.sv
// Shared constants, register indexes and sine table generator for the oscillator.
package mwpo_pkg;

	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 32;
	localparam int OFFSET_W    = 33;
	localparam int BASE_W      = 32;
	localparam int WAVE_W      = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_WAVEFORM_SELECT = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BASE_INCREMENT  = 8'd1;

	localparam logic [WAVE_W-1:0] WAVE_SINE     = 2'd0;
	localparam logic [WAVE_W-1:0] WAVE_SAW      = 2'd1;
	localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 2'd2;
	localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 2'd3;

	localparam int     CORDIC_STEPS    = 30;
	localparam longint CORDIC_GAIN_Q30 = 652032874;

	// atan(2^-i) in units of 2^-32 turn
	localparam longint ATAN_TURNS [CORDIC_STEPS] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81,
		41, 20, 10, 5, 3, 1
	};

	// sine of table entry idx in Q1.(sample_bits-1), evaluated at elaboration
	function automatic longint sine_entry(int idx, int table_bits, int sample_bits);
		logic [31:0] angle;
		logic [1:0]  quad;
		longint      r;
		longint      x;
		longint      y;
		longint      z;
		longint      nx;
		longint      mag;
		longint      full_pos;
		angle = 32'(idx) << (32 - table_bits);
		quad  = angle[31:30];
		r     = longint'(angle[29:0]);
		if (quad[0]) begin
			r = (longint'(1) << 30) - r;
		end
		x = CORDIC_GAIN_Q30;
		y = 0;
		z = r;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y  = y + (x >>> i);
				z  = z - ATAN_TURNS[i];
			end else begin
				nx = x + (y >>> i);
				y  = y - (x >>> i);
				z  = z + ATAN_TURNS[i];
			end
			x = nx;
		end
		if (y < 0) begin
			y = 0;
		end
		if (y > (longint'(1) << 30)) begin
			y = longint'(1) << 30;
		end
		full_pos = (longint'(1) << (sample_bits - 1)) - 1;
		mag      = (y * full_pos + (longint'(1) << 29)) >>> 30;
		return quad[1] ? -mag : mag;
	endfunction

endpackage

>>> design/mwpo_incr.sv
// Increment adder with clamp to the range zero to Nyquist.
module mwpo_incr import mwpo_pkg::*; #(
	parameter int PHASE_BITS = 32
) (
	input  logic [BASE_W-1:0]          base_increment,
	input  logic signed [OFFSET_W-1:0] increment_offset,
	output logic [PHASE_BITS-1:0]      increment,
	output logic                       clamped
);

	localparam int SUM_W = (PHASE_BITS + 1 > BASE_W + 2) ? PHASE_BITS + 1 : BASE_W + 2;
	localparam logic signed [SUM_W-1:0] NYQ =
		{{(SUM_W-PHASE_BITS){1'b0}}, 1'b1, {(PHASE_BITS-1){1'b0}}};

	logic signed [SUM_W-1:0] sum;

	assign sum = SUM_W'($signed({1'b0, base_increment})) + SUM_W'(increment_offset);

	always_comb begin
		priority if (sum < 0) begin
			increment = '0;
			clamped   = 1'b1;
		end else if (sum > NYQ) begin
			increment = NYQ[PHASE_BITS-1:0];
			clamped   = 1'b1;
		end else begin
			increment = sum[PHASE_BITS-1:0];
			clamped   = 1'b0;
		end
	end

endmodule

>>> design/mwpo_sine_rom.sv
// Sine table with registered read.
module mwpo_sine_rom import mwpo_pkg::*; #(
	parameter int SINE_TABLE_BITS = 10,
	parameter int SAMPLE_BITS     = 16
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [SINE_TABLE_BITS-1:0] addr,
	output logic [SAMPLE_BITS-1:0]     data_s2
);

	localparam int DEPTH = 1 << SINE_TABLE_BITS;

	typedef logic [SAMPLE_BITS-1:0] rom_t [DEPTH];

	function automatic rom_t build_rom();
		rom_t tbl;
		for (int i = 0; i < DEPTH; i++) begin
			tbl[i] = SAMPLE_BITS'(sine_entry(i, SINE_TABLE_BITS, SAMPLE_BITS));
		end
		return tbl;
	endfunction

	localparam rom_t ROM_TABLE = build_rom();

	always_ff @(posedge clk) begin
		if (en) begin
			data_s2 <= ROM_TABLE[addr];
		end
	end

endmodule

>>> design/mwpo_shape.sv
// Waveform shaping from phase and sine table data.
module mwpo_shape import mwpo_pkg::*; #(
	parameter int PHASE_BITS  = 32,
	parameter int SAMPLE_BITS = 16
) (
	input  logic [WAVE_W-1:0]      waveform_select,
	input  logic [PHASE_BITS-1:0]  phase,
	input  logic [SAMPLE_BITS-1:0] sine_data,
	output logic [SAMPLE_BITS-1:0] sample
);

	localparam int EXT_W = PHASE_BITS + SAMPLE_BITS + 1;
	localparam logic signed [SAMPLE_BITS+1:0] HALF_W = {3'b001, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [SAMPLE_BITS+1:0] FULL_W = {3'b000, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] POS_ONE = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] NEG_ONE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic [EXT_W-1:0]               ext;
	logic [SAMPLE_BITS-1:0]         saw;
	logic signed [SAMPLE_BITS:0]    tri_u;
	logic signed [SAMPLE_BITS+1:0]  tri_e;
	logic signed [SAMPLE_BITS+1:0]  tri_abs;
	logic signed [SAMPLE_BITS+1:0]  tri_t;
	logic [SAMPLE_BITS-1:0]         tri_v;

	assign ext     = {phase, {(SAMPLE_BITS+1){1'b0}}};
	assign saw     = {~ext[EXT_W-1], ext[EXT_W-2:PHASE_BITS+1]};
	assign tri_u   = {~ext[EXT_W-1], ext[EXT_W-2:PHASE_BITS]};
	assign tri_e   = (SAMPLE_BITS+2)'(tri_u);
	assign tri_abs = (tri_e < 0) ? -tri_e : tri_e;
	assign tri_t   = tri_abs - HALF_W;
	assign tri_v   = (tri_t > FULL_W) ? POS_ONE : tri_t[SAMPLE_BITS-1:0];

	always_comb begin
		unique case (waveform_select)
			WAVE_SINE:     sample = sine_data;
			WAVE_SAW:      sample = saw;
			WAVE_SQUARE:   sample = phase[PHASE_BITS-1] ? NEG_ONE : POS_ONE;
			WAVE_TRIANGLE: sample = tri_v;
			default:       sample = sine_data;
		endcase
	end

endmodule

>>> design/multi_waveform_phase_oscillator.sv
// Top level of the multi-waveform phase oscillator.
// Throughput: one request per cycle unless the output stalls the pipeline.
// Stages: input register, then sine table read register that also holds the result.
// Reset: phase, waveform select and base increment clear to zero, pipeline empties.
// The sine table is a constant ROM and needs no fill after reset.
module multi_waveform_phase_oscillator import mwpo_pkg::*; #(
	parameter int PHASE_BITS      = 32,
	parameter int SINE_TABLE_BITS = 10,
	parameter int SAMPLE_BITS     = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_INDEX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [OFFSET_W-1:0]    increment_offset,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample_value,
	output logic                          increment_clamped
);

	logic [WAVE_W-1:0]          waveform_q;
	logic [BASE_W-1:0]          base_q;
	logic [PHASE_BITS-1:0]      phase_q;
	logic                       valid_s1;
	logic signed [OFFSET_W-1:0] offset_s1;
	logic                       valid_s2;
	logic [PHASE_BITS-1:0]      phase_s2;
	logic                       clamped_s2;
	logic [SAMPLE_BITS-1:0]     sine_s2;
	logic [SAMPLE_BITS-1:0]     sample;
	logic [PHASE_BITS-1:0]      increment;
	logic                       clamped;
	logic                       adv_s1;

	assign cfg_ready = 1'b1;
	assign adv_s1    = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waveform_q <= '0;
			base_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_WAVEFORM_SELECT) begin
				waveform_q <= cfg_data[WAVE_W-1:0];
			end else if (cfg_index == REG_BASE_INCREMENT) begin
				base_q <= cfg_data[BASE_W-1:0];
			end
		end
	end

	mwpo_incr #(
		.PHASE_BITS(PHASE_BITS)
	) u_incr (
		.base_increment  (base_q),
		.increment_offset(offset_s1),
		.increment       (increment),
		.clamped         (clamped)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			phase_q  <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
				phase_q  <= phase_q + increment;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			offset_s1 <= increment_offset;
		end
		if (adv_s1) begin
			phase_s2   <= phase_q;
			clamped_s2 <= clamped;
		end
	end

	mwpo_sine_rom #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) u_sine_rom (
		.clk    (clk),
		.en     (adv_s1),
		.addr   (phase_q[PHASE_BITS-1 -: SINE_TABLE_BITS]),
		.data_s2(sine_s2)
	);

	mwpo_shape #(
		.PHASE_BITS (PHASE_BITS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_shape (
		.waveform_select(waveform_q),
		.phase          (phase_s2),
		.sine_data      (sine_s2),
		.sample         (sample)
	);

	assign out_valid         = valid_s2;
	assign sample_value      = $signed(sample);
	assign increment_clamped = clamped_s2;

	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(phase_q))
		else $error("phase moved without a request advancing");

	a_phase_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> phase_q == $past(phase_q + increment))
		else $error("phase did not advance by the clamped increment");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && !out_ready)
		else $error("input stalled while the pipeline could move");

	a_s2_capture: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> valid_s2 && phase_s2 == $past(phase_q))
		else $error("result stage missed the phase of its request");

endmodule
